// ===== rtl/prc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prc_pkg: shared types, constants and helpers of the pixel recolor engine
// Holds the opcode set, the pipeline word and the divider step function.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Hue is kept in fixed point with 16 fraction bits; six sextants make a turn.
  localparam int unsigned HUE_FRAC_BITS = 16;
  localparam logic [19:0] HUE_FULL = 20'd393216;

  // (x + 127) / 255 is done as ((x + 127) * 32897) >> 23, exact for 16-bit x.
  localparam logic [15:0] MUL_ROUND = 16'd127;
  localparam logic [15:0] RECIP_255 = 16'd32897;

  // Quotient bits resolved by each call of div_steps.
  localparam int unsigned DIV_STEPS = 4;

  typedef enum logic [1:0] {
    OP_MULTIPLY    = 2'd0,
    OP_PURPLE_TINT = 2'd1,
    OP_HUE_ROTATE  = 2'd2,
    OP_TINT        = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [8:0]  rem;
    logic [16:0] q;
  } div_t;

  // One word of the pipeline. Each stage fills in the fields it owns.
  typedef struct packed {
    opcode_t          op;
    logic [31:0]      px;
    logic [31:0]      arg;
    logic [7:0]       mn;
    logic [7:0]       mx;
    logic [7:0]       d;
    logic [2:0]       sext;
    logic [10:0]      argmod;
    logic             pass;
    div_t             div;
    logic [3:0][15:0] prod;
    logic [18:0]      hue;
    logic [23:0]      hprod;
    logic [31:0]      res;
  } stage_t;

  // Restoring division, DIV_STEPS quotient bits. The remainder stays below d.
  function automatic div_t div_steps(input div_t s, input logic [7:0] d);
    div_t        t;
    logic [8:0]  r;
    logic        qb;
    t = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {t.rem[7:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r  = r - {1'b0, d};
        qb = 1'b1;
      end else begin
        qb = 1'b0;
      end
      t.rem = r;
      t.q   = {t.q[15:0], qb};
    end
    return t;
  endfunction

  // Residue modulo 3 of a 23-bit value: base-4 digit sums fold it down.
  function automatic logic [1:0] mod3_23(input logic [22:0] v);
    logic [23:0] w;
    logic [5:0]  s1;
    logic [3:0]  s2;
    w  = {1'b0, v};
    s1 = '0;
    for (int i = 0; i < 12; i++) begin
      s1 = s1 + 6'(w[2*i +: 2]);
    end
    s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
    if (s2 >= 4'd6) begin
      s2 = s2 - 4'd6;
    end
    if (s2 >= 4'd3) begin
      s2 = s2 - 4'd3;
    end
    return s2[1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/prc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prc_in_if: input channel of the pixel recolor engine
// Carries one opcode, source pixel and color argument per word.
// ----------------------------------------------------------------------------
interface prc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] pixel_in;
  logic [31:0] color_arg;

  modport source (output valid, input ready, output opcode, output pixel_in,
                  output color_arg);
  modport sink (input valid, output ready, input opcode, input pixel_in,
                input color_arg);
endinterface
`default_nettype wire

// ===== rtl/prc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prc_out_if: output channel of the pixel recolor engine
// Carries one recolored pixel per word.
// ----------------------------------------------------------------------------
interface prc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;

  modport source (output valid, input ready, output pixel_out);
  modport sink (input valid, output ready, input pixel_out);
endinterface
`default_nettype wire

// ===== rtl/prc_pipe_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prc_pipe_stage: one register stage of the recolor pipeline
// Holds a word and its valid bit; it takes a new word when it is empty or
// when the next stage takes the one it holds.
// ----------------------------------------------------------------------------
module prc_pipe_stage
  import prc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   up_valid,
  output logic   up_ready,
  input  stage_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output stage_t dn_data
);

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= up_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pixel_recolor_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_recolor_engine: per-pixel multiply, tint, purple-gated tint and hue
// rotation of 32-bit pixels
// ----------------------------------------------------------------------------
// Usage:
//   src carries one word per pixel: opcode, pixel_in and color_arg. dst returns
//   one word with pixel_out for each accepted pixel, in order.
//   The block is an eight-stage pipeline: a pixel accepted on src passes
//   through the stage registers 0 to 7 in order and is offered on dst from
//   stage 7. One pixel enters in every cycle while dst does not stall; the hue
//   divider, which resolves its 17 quotient bits over four stages, sets the depth.
//   Each stage moves its word forward as soon as the next one is free, so
//   src.ready stays high while any stage holds a bubble. When dst stalls the
//   pipeline fills up and src.ready drops only once all eight stages are
//   full; nothing is lost or repeated.
//   Reset empties the pipeline; it holds no other state, so no word needs to
//   be written before the first pixel.
// ----------------------------------------------------------------------------
module pixel_recolor_engine
  import prc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  prc_in_if.sink    src,
  prc_out_if.source dst
);

  localparam int unsigned NUM_STAGES = 8;

  stage_t                pipe_d [NUM_STAGES];
  stage_t                pipe_q [NUM_STAGES];
  logic [NUM_STAGES-1:0] pipe_v;
  logic [NUM_STAGES-1:0] pipe_rdy;

  // Stage 0: min, max, sextant and numerator, gates, byte products.
  function automatic stage_t stage_front(input logic [1:0] opc, input logic [31:0] px,
                                         input logic [31:0] arg);
    stage_t     s;
    logic [7:0] c0, c1, c2, mn, mx, num;
    s   = '0;
    c0  = px[7:0];
    c1  = px[15:8];
    c2  = px[23:16];
    mx  = c0;
    mn  = c0;
    if (c1 > mx) mx = c1;
    if (c2 > mx) mx = c2;
    if (c1 < mn) mn = c1;
    if (c2 < mn) mn = c2;
    num = '0;
    // Later sextant matches override earlier ones.
    if (c0 == mn && c2 == mx) begin s.sext = 3'd0; num = c1 - mn; end
    if (c0 == mn && c1 == mx) begin s.sext = 3'd1; num = mx - c2; end
    if (c2 == mn && c1 == mx) begin s.sext = 3'd2; num = c0 - mn; end
    if (c0 == mx && c2 == mn) begin s.sext = 3'd3; num = mx - c1; end
    if (c1 == mn && c0 == mx) begin s.sext = 3'd4; num = c2 - mn; end
    if (c1 == mn && c2 == mx) begin s.sext = 3'd5; num = mx - c0; end
    s.op      = opcode_t'(opc);
    s.px      = px;
    s.arg     = arg;
    s.mn      = mn;
    s.mx      = mx;
    s.d       = mx - mn;
    s.div.rem = {1'b0, num};
    s.div.q   = '0;
    s.argmod  = {mod3_23(arg[31:9]), arg[8:0]};
    unique case (s.op)
      OP_HUE_ROTATE:  s.pass = (mn == mx);
      OP_PURPLE_TINT: s.pass = !(c0 == c2 && c0 > c1);
      default:        s.pass = 1'b0;
    endcase
    for (int k = 0; k < 4; k++) begin
      s.prod[k] = {8'b0, px[8*k +: 8]} * {8'b0, arg[8*k +: 8]};
    end
    return s;
  endfunction

  // Stage 1: top quotient bit and first divider steps; tint products.
  function automatic stage_t stage_div_first(input stage_t p);
    stage_t     s;
    logic [8:0] span;
    s = p;
    if (s.div.rem >= {1'b0, s.d}) begin
      s.div.q   = 17'd1;
      s.div.rem = s.div.rem - {1'b0, s.d};
    end
    s.div = div_steps(s.div, s.d);
    span  = {1'b0, s.mx} - {1'b0, s.mn} + 9'd1;
    if (s.op != OP_MULTIPLY) begin
      for (int k = 0; k < 3; k++) begin
        s.prod[k] = {7'b0, span} * {8'b0, s.arg[8*k +: 8]};
      end
    end
    return s;
  endfunction

  // Stage 2: divider steps; pass-through, multiply and tint results.
  function automatic stage_t stage_div_res(input stage_t p);
    stage_t      s;
    logic [15:0] x;
    logic [31:0] m;
    s     = p;
    s.div = div_steps(s.div, s.d);
    if (s.pass) begin
      s.res = s.px;
    end else if (s.op == OP_MULTIPLY) begin
      for (int k = 0; k < 4; k++) begin
        x = s.prod[k] + MUL_ROUND;
        m = {16'b0, x} * {16'b0, RECIP_255};
        s.res[8*k +: 8] = m[30:23];
      end
    end else begin
      s.res = {s.px[31:24], s.mn + s.prod[2][15:8], s.mn + s.prod[1][15:8],
               s.mn + s.prod[0][15:8]};
    end
    return s;
  endfunction

  function automatic stage_t stage_div(input stage_t p);
    stage_t s;
    s     = p;
    s.div = div_steps(s.div, s.d);
    return s;
  endfunction

  // Stage 5: hue plus shift, wrapped once into a full turn.
  function automatic stage_t stage_hue(input stage_t p);
    stage_t      s;
    logic [19:0] sum;
    s   = p;
    sum = {1'b0, s.sext, 16'b0} + {3'b0, s.div.q} + {1'b0, s.argmod, 8'b0};
    if (sum >= HUE_FULL) begin
      sum = sum - HUE_FULL;
    end
    s.hue = sum[18:0];
    return s;
  endfunction

  function automatic stage_t stage_scale(input stage_t p);
    stage_t s;
    s       = p;
    s.hprod = {16'b0, s.d} * {8'b0, s.hue[HUE_FRAC_BITS-1:0]};
    return s;
  endfunction

  // Stage 7: place min, max and the ramp values by sextant.
  function automatic stage_t stage_final(input stage_t p);
    stage_t     s;
    logic [7:0] fr, f2;
    s  = p;
    fr = s.mn + s.hprod[23:16];
    f2 = s.mx + s.mn - fr;
    if (s.op == OP_HUE_ROTATE && !s.pass) begin
      unique case (s.hue[18:16])
        3'd0:    s.res = {s.px[31:24], s.mx, fr, s.mn};
        3'd1:    s.res = {s.px[31:24], f2, s.mx, s.mn};
        3'd2:    s.res = {s.px[31:24], s.mn, s.mx, fr};
        3'd3:    s.res = {s.px[31:24], s.mn, f2, s.mx};
        3'd4:    s.res = {s.px[31:24], fr, s.mn, s.mx};
        default: s.res = {s.px[31:24], s.mx, s.mn, f2};
      endcase
    end
    return s;
  endfunction

  assign pipe_d[0] = stage_front(src.opcode, src.pixel_in, src.color_arg);
  assign pipe_d[1] = stage_div_first(pipe_q[0]);
  assign pipe_d[2] = stage_div_res(pipe_q[1]);
  assign pipe_d[3] = stage_div(pipe_q[2]);
  assign pipe_d[4] = stage_div(pipe_q[3]);
  assign pipe_d[5] = stage_hue(pipe_q[4]);
  assign pipe_d[6] = stage_scale(pipe_q[5]);
  assign pipe_d[7] = stage_final(pipe_q[6]);

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    logic up_valid;
    logic dn_ready;
    if (i == 0) begin : g_first
      assign up_valid = src.valid;
    end else begin : g_mid
      assign up_valid = pipe_v[i-1];
    end
    if (i == NUM_STAGES - 1) begin : g_last
      assign dn_ready = dst.ready;
    end else begin : g_inner
      assign dn_ready = pipe_rdy[i+1];
    end
    prc_pipe_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (up_valid),
      .up_ready (pipe_rdy[i]),
      .up_data  (pipe_d[i]),
      .dn_valid (pipe_v[i]),
      .dn_ready (dn_ready),
      .dn_data  (pipe_q[i])
    );
  end

  assign src.ready     = pipe_rdy[0];
  assign dst.valid     = pipe_v[NUM_STAGES-1];
  assign dst.pixel_out = pipe_q[NUM_STAGES-1].res;

  // The input is refused only when every stage holds a word.
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    !src.ready |-> (&pipe_v))
    else $error("input refused while the pipeline has a bubble");

  // After the last divider stage the remainder is below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (pipe_v[4] && pipe_q[4].op == OP_HUE_ROTATE && !pipe_q[4].pass)
      |-> (pipe_q[4].div.rem < {1'b0, pipe_q[4].d}))
    else $error("divider remainder not below divisor");

  // The wrapped hue lies within one turn.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    (pipe_v[5] && pipe_q[5].op == OP_HUE_ROTATE && !pipe_q[5].pass)
      |-> ({1'b0, pipe_q[5].hue} < HUE_FULL))
    else $error("hue outside one turn");

  // The ramp offset stays below the span, so the ramp value stays in range.
  a_ramp_range: assert property (@(posedge clk) disable iff (rst)
    (pipe_v[6] && pipe_q[6].op == OP_HUE_ROTATE && !pipe_q[6].pass)
      |-> (pipe_q[6].hprod[23:16] < pipe_q[6].d))
    else $error("hue ramp offset exceeds span");

endmodule
`default_nettype wire
